// File: rtl/core/pcc_pkg.sv
// Package for the palette color-cycling crossfade block.
// Request and result structs, function codes, register indexes, FSM states.
// No dependencies.
`default_nettype none

package pcc_pkg;

  localparam int NUM_W = 24;  // numerator of one channel blend
  localparam int QUO_W = 8;   // blended channel
  localparam int IDX_W = 5;   // palette index held in state
  localparam int TL_W  = 16;
  localparam int CC_W  = 5;

  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_WRITE   = 2'd1;
  localparam logic [1:0] FUNC_LOAD    = 2'd2;
  localparam logic [1:0] FUNC_RESTART = 2'd3;

  localparam logic CFG_TLEN   = 1'b0;
  localparam logic CFG_CCOUNT = 1'b1;

  localparam logic [31:0] PAL_RESET = 32'h0000_00FF;
  localparam logic [16:0] PHASE_ONE = 17'h1_0000;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  entry_index;
    logic [31:0] entry_color;
    logic [16:0] phase;
    logic [3:0]  load_past;
    logic [3:0]  load_future;
  } pcc_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pcc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } pcc_state_t;

endpackage

`default_nettype wire

// File: rtl/core/palette_cycle_crossfade.sv
// Palette color cycling with a linear crossfade between neighboring entries.
// Top level; depends on pcc_pkg and pcc_div.
`default_nettype none

// Each request updates the cycling state (tick, palette write, state load or
// restart) on the edge it is accepted, then produces one RGBA result blended
// as (past*(T-w)+future*w)/T per channel, truncated. Requests are accepted only
// in the idle state, so a new request is not taken until the result of the last
// one has been loaded into the output register. The four channels are blended
// in turn on one shared bit-serial divider: a palette read step, then per
// channel a multiply step, the divider steps and a step to store the quotient,
// then a step to load the output register. While a result waits in the
// output register the next request is still accepted, but its result holds
// in the last step until the register frees. The palette is a synchronous
// memory with per-entry valid bits; unwritten entries read as opaque black.
module palette_cycle_crossfade
  import pcc_pkg::*;
#(
  parameter int MAX_COLORS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pcc_in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pcc_out_t               out_data,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [TL_W-1:0]   cfg_data
);

  localparam int PAL_AW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam logic [CC_W-1:0] MAX_CLAMP =
    CC_W'((MAX_COLORS > 31) ? 31 : MAX_COLORS);
  localparam logic [IDX_W-1:0] FUT_RESET = (MAX_COLORS == 1) ? IDX_W'(0) : IDX_W'(1);

  pcc_state_t state, state_next;

  logic [TL_W-1:0]   tlen;
  logic [CC_W-1:0]   ccount;
  logic [TL_W-1:0]   frame;
  logic [IDX_W-1:0]  past_idx;
  logic [IDX_W-1:0]  future_idx;
  logic [1:0]        chan;
  pcc_out_t          res;

  logic [31:0]             pal_mem [MAX_COLORS];
  logic [MAX_COLORS-1:0]   pal_vld;
  logic [31:0]             rd_past;
  logic [31:0]             rd_future;
  logic                    vld_past;
  logic                    vld_future;

  logic                    accept;
  logic                    out_load;
  logic                    div_start;
  logic                    div_done;
  logic [QUO_W-1:0]        div_quot;

  logic [CC_W-1:0]   eff;
  logic [IDX_W-1:0]  past_sel;
  logic [IDX_W-1:0]  future_sel;
  logic [IDX_W-1:0]  past_step;
  logic [IDX_W-1:0]  future_step;
  logic [16:0]       phase_sat;
  logic [31:0]       load_prod;
  logic              wr_hit;

  logic [31:0]       col_past;
  logic [31:0]       col_future;
  logic [7:0]        p_byte;
  logic [7:0]        f_byte;
  logic [TL_W-1:0]   wgt;
  logic [NUM_W-1:0]  blend_num;
  logic [7:0]        chan_val;

  assign accept = in_valid && in_ready;

  always_comb begin
    if (ccount == '0) begin
      eff = CC_W'(1);
    end else if (ccount > MAX_CLAMP) begin
      eff = MAX_CLAMP;
    end else begin
      eff = ccount;
    end
  end

  function automatic logic [IDX_W-1:0] step_idx(logic [IDX_W-1:0] idx,
                                                logic [CC_W-1:0] cnt);
    logic [IDX_W:0] n;
    n = {1'b0, idx} + 1'b1;
    return (n >= {1'b0, cnt}) ? '0 : n[IDX_W-1:0];
  endfunction

  assign past_step   = step_idx(past_idx, eff);
  assign future_step = step_idx(future_idx, eff);
  assign phase_sat   = (in_data.phase > PHASE_ONE) ? PHASE_ONE : in_data.phase;
  assign load_prod   = 32'(phase_sat) * 32'(tlen);
  assign wr_hit      = 32'(in_data.entry_index) < MAX_COLORS;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tlen   <= TL_W'(60);
      ccount <= CC_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TLEN:   tlen   <= cfg_data;
        CFG_CCOUNT: ccount <= cfg_data[CC_W-1:0];
        default:    ;
      endcase
    end
  end

  // Cycling state, updated on request acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      frame      <= '0;
      past_idx   <= '0;
      future_idx <= FUT_RESET;
    end else if (accept) begin
      case (in_data.func)
        FUNC_TICK: begin
          if (frame >= tlen) begin
            frame      <= '0;
            past_idx   <= past_step;
            future_idx <= future_step;
          end else begin
            frame <= frame + 1'b1;
          end
        end
        FUNC_LOAD: begin
          frame      <= load_prod[31:16];
          past_idx   <= (CC_W'(in_data.load_past) < eff) ? IDX_W'(in_data.load_past) : '0;
          future_idx <= (CC_W'(in_data.load_future) < eff) ?
                        IDX_W'(in_data.load_future) : '0;
        end
        FUNC_RESTART: begin
          frame      <= '0;
          past_idx   <= '0;
          future_idx <= (eff == CC_W'(1)) ? '0 : IDX_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Palette memory
  assign past_sel   = (CC_W'(past_idx) < eff) ? past_idx : '0;
  assign future_sel = (CC_W'(future_idx) < eff) ? future_idx : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_vld <= '0;
    end else if (accept && in_data.func == FUNC_WRITE && wr_hit) begin
      pal_vld[PAL_AW'(in_data.entry_index)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.func == FUNC_WRITE && wr_hit) begin
      pal_mem[PAL_AW'(in_data.entry_index)] <= in_data.entry_color;
    end
    if (state == ST_READ) begin
      rd_past    <= pal_mem[PAL_AW'(past_sel)];
      rd_future  <= pal_mem[PAL_AW'(future_sel)];
      vld_past   <= pal_vld[PAL_AW'(past_sel)];
      vld_future <= pal_vld[PAL_AW'(future_sel)];
    end
  end

  // Per-channel blend numerator
  assign col_past   = vld_past ? rd_past : PAL_RESET;
  assign col_future = vld_future ? rd_future : PAL_RESET;

  always_comb begin
    case (chan)
      2'd0: begin
        p_byte = col_past[31:24];
        f_byte = col_future[31:24];
      end
      2'd1: begin
        p_byte = col_past[23:16];
        f_byte = col_future[23:16];
      end
      2'd2: begin
        p_byte = col_past[15:8];
        f_byte = col_future[15:8];
      end
      default: begin
        p_byte = col_past[7:0];
        f_byte = col_future[7:0];
      end
    endcase
  end

  assign wgt       = (frame > tlen) ? tlen : frame;
  assign blend_num = NUM_W'(p_byte) * NUM_W'(tlen - wgt) + NUM_W'(f_byte) * NUM_W'(wgt);
  assign chan_val  = (tlen == '0) ? p_byte : div_quot;

  pcc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (blend_num),
    .den   (tlen),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      chan  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_READ) begin
        chan <= '0;
      end else if (state == ST_DIV && div_done) begin
        chan <= chan + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_MUL;
      ST_MUL: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = (chan == 2'd3) ? ST_OUT : ST_MUL;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV && div_done) begin
      case (chan)
        2'd0:    res.red   <= chan_val;
        2'd1:    res.green <= chan_val;
        2'd2:    res.blue  <= chan_val;
        default: res.alpha <= chan_val;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pcc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Quotient must fit in QUO_W bits (numerator below den << QUO_W).
// Depends on pcc_pkg.
`default_nettype none

module pcc_div
  import pcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [TL_W-1:0]   den,
  output logic                   done,
  output logic [QUO_W-1:0]       quot
);

  localparam int DSR_W = TL_W + QUO_W - 1;
  localparam int CNT_W = $clog2(QUO_W);

  logic                      busy;
  logic [CNT_W-1:0]          cnt;
  logic [NUM_W-1:0]          rem;
  logic [DSR_W-1:0]          dsr;
  logic                      fits;

  assign fits = rem >= NUM_W'(dsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUO_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsr  <= {den, {(QUO_W-1){1'b0}}};
      quot <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - NUM_W'(dsr);
      end
      quot <= {quot[QUO_W-2:0], fits};
      dsr  <= dsr >> 1;
    end
  end

endmodule

`default_nettype wire

// File: sim/pcc_checker.sv
// Checker for palette_cycle_crossfade: tracks config writes and accepted requests,
// predicts each blended color and compares results in order.
// Depends on pcc_pkg.
module pcc_checker
  import pcc_pkg::*;
#(
  parameter int MAX_COLORS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            in_ready,
  input  wire pcc_in_t         in_data,
  input  wire logic            out_valid,
  input  wire logic            out_ready,
  input  wire pcc_out_t        out_data,
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [TL_W-1:0] cfg_data,
  output int                   errors,
  output int                   pending,
  output int                   checked
);

  localparam logic [TL_W-1:0] TLEN_RESET   = 16'd60;
  localparam logic [CC_W-1:0] CCOUNT_RESET = 5'd16;

  logic [31:0]     pal_model [MAX_COLORS];
  logic [TL_W-1:0] tlen;
  logic [TL_W-1:0] frame_ctr;
  logic [CC_W-1:0] ccount;
  int unsigned     past_idx;
  int unsigned     future_idx;
  pcc_out_t        expected_colors [$];
  pcc_out_t        want;

  function automatic int unsigned live_count();
    if (ccount == 0) return 1;
    if (ccount > MAX_COLORS) return MAX_COLORS;
    return ccount;
  endfunction

  function automatic int unsigned next_idx(int unsigned idx);
    return (idx + 1 >= live_count()) ? 0 : idx + 1;
  endfunction

  function automatic logic [31:0] pal_read(int unsigned idx);
    return pal_model[(idx >= live_count()) ? 0 : idx];
  endfunction

  task automatic rewind_cycle();
    frame_ctr  = '0;
    past_idx   = 0;
    future_idx = (live_count() == 1) ? 0 : 1;
  endtask

  function automatic pcc_out_t blend_now();
    logic [31:0] pc;
    logic [31:0] fc;
    int unsigned t;
    int unsigned w;
    int unsigned p;
    int unsigned f;
    int unsigned v;
    logic [7:0]  ch [4];
    pc = pal_read(past_idx);
    fc = pal_read(future_idx);
    t  = tlen;
    w  = (frame_ctr > tlen) ? t : frame_ctr;
    for (int k = 0; k < 4; k++) begin
      p = pc[31 - 8 * k -: 8];
      f = fc[31 - 8 * k -: 8];
      v = (t == 0) ? p : (p * (t - w) + f * w) / t;
      ch[k] = 8'(v);
    end
    return {ch[0], ch[1], ch[2], ch[3]};
  endfunction

  task automatic advance(pcc_in_t r);
    longint unsigned ph;
    case (r.func)
      FUNC_TICK: begin
        if (frame_ctr >= tlen) begin
          frame_ctr  = '0;
          past_idx   = next_idx(past_idx);
          future_idx = next_idx(future_idx);
        end else begin
          frame_ctr = frame_ctr + 1'b1;
        end
      end
      FUNC_WRITE: begin
        if (r.entry_index < MAX_COLORS) pal_model[r.entry_index] = r.entry_color;
      end
      FUNC_LOAD: begin
        ph         = (r.phase > PHASE_ONE) ? PHASE_ONE : r.phase;
        frame_ctr  = TL_W'((ph * tlen) >> 16);
        past_idx   = (r.load_past < live_count()) ? r.load_past : 0;
        future_idx = (r.load_future < live_count()) ? r.load_future : 0;
      end
      FUNC_RESTART: rewind_cycle();
    endcase
    expected_colors.push_back(blend_now());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (pal_model[i]) pal_model[i] = PAL_RESET;
      tlen    = TLEN_RESET;
      ccount  = CCOUNT_RESET;
      rewind_cycle();
      expected_colors.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TLEN) tlen = cfg_data;
        else ccount = cfg_data[CC_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          errors++;
          $display("%0t: unexpected color, expected none, actual %h", $time, out_data);
        end else begin
          want = expected_colors.pop_front();
          checked++;
          if (want.red !== out_data.red || want.green !== out_data.green ||
              want.blue !== out_data.blue || want.alpha !== out_data.alpha) begin
            errors++;
            $display("%0t: color mismatch, expected r%h g%h b%h a%h, actual r%h g%h b%h a%h",
                     $time, want.red, want.green, want.blue, want.alpha,
                     out_data.red, out_data.green, out_data.blue, out_data.alpha);
          end
        end
      end
      if (in_valid && in_ready) advance(in_data);
    end
    pending = expected_colors.size();
  end

endmodule

// File: sim/palette_cycle_crossfade_tb.sv
// Testbench top for palette_cycle_crossfade: directed and random requests
// under random stalls on both channels (none in the last random phase), verdict
// from pcc_checker. Depends on pcc_pkg, pcc_checker and the block.
module palette_cycle_crossfade_tb;
  import pcc_pkg::*;

  localparam int MAX_COLORS  = 16;
  localparam int RAND_PHASES = 11;
  localparam int PHASE_ITEMS = 45;
  localparam int TIMEOUT     = 3_000_000;

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  pcc_in_t         in_data;
  logic            out_valid;
  logic            out_ready;
  pcc_out_t        out_data;
  logic            cfg_we;
  logic            cfg_index;
  logic [TL_W-1:0] cfg_data;
  int              errors;
  int              pending;
  int              checked;
  bit              steady;
  int              fn_count [4];
  int              reg_writes;

  palette_cycle_crossfade #(.MAX_COLORS(MAX_COLORS)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pcc_checker #(.MAX_COLORS(MAX_COLORS)) i_checker (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #(TIMEOUT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side back-pressure
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (!steady && $urandom_range(0, 2) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  end

  function automatic pcc_in_t req(logic [1:0] f, logic [3:0] ei, logic [31:0] ec,
                                  logic [16:0] ph, logic [3:0] lp, logic [3:0] lf);
    pcc_in_t r;
    r.func        = f;
    r.entry_index = ei;
    r.entry_color = ec;
    r.phase       = ph;
    r.load_past   = lp;
    r.load_future = lf;
    return r;
  endfunction

  function automatic pcc_in_t random_req();
    pcc_in_t     r;
    int unsigned pick;
    r.entry_index = 4'($urandom);
    r.entry_color = $urandom;
    r.load_past   = 4'($urandom);
    r.load_future = 4'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0) r.phase = PHASE_ONE;
    else if (pick == 1) r.phase = 17'($urandom_range(0, 131071));
    else r.phase = 17'($urandom_range(0, 65536));
    pick = $urandom_range(0, 99);
    if (pick < 45) r.func = FUNC_TICK;
    else if (pick < 65) r.func = FUNC_WRITE;
    else if (pick < 92) r.func = FUNC_LOAD;
    else r.func = FUNC_RESTART;
    return r;
  endfunction

  function automatic logic [TL_W-1:0] random_tlen();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return TL_W'($urandom_range(0, 12));
    if (pick < 9) return TL_W'($urandom_range(13, 300));
    return TL_W'($urandom_range(0, 65535));
  endfunction

  task automatic send_req(pcc_in_t r);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = r;
    fn_count[r.func]++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [TL_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    reg_writes++;
  endtask

  initial begin
    logic [TL_W-1:0] tl;
    logic [CC_W-1:0] cc;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_TLEN;
    cfg_data   = '0;
    steady     = 1'b0;
    reg_writes = 0;
    foreach (fn_count[i]) fn_count[i] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: T 60, sixteen colors
    send_req(req(FUNC_TICK, 4'h0, 32'h0, 17'h0, 4'h0, 4'h0));
    send_req(req(FUNC_WRITE, 4'h0, 32'h0000_0000, 17'h0, 4'h0, 4'h0));
    send_req(req(FUNC_WRITE, 4'hF, 32'hFFFF_FFFF, 17'h0, 4'h0, 4'h0));
    send_req(req(FUNC_WRITE, 4'h1, 32'h12AB_7F80, 17'h0, 4'h0, 4'h0));
    send_req(req(FUNC_LOAD, 4'h0, 32'h0, PHASE_ONE, 4'h0, 4'h1));
    send_req(req(FUNC_TICK, 4'h0, 32'h0, 17'h0, 4'h0, 4'h0));
    send_req(req(FUNC_LOAD, 4'hF, 32'hFFFF_FFFF, 17'h1_FFFF, 4'hF, 4'h0));
    send_req(req(FUNC_LOAD, 4'h0, 32'h0, 17'h0, 4'hF, 4'hF));
    send_req(req(FUNC_LOAD, 4'h0, 32'h0, 17'h0_8000, 4'h0, 4'hF));
    send_req(req(FUNC_RESTART, 4'h0, 32'h0, 17'h0, 4'h0, 4'h0));

    // zero-length fade with a single color
    drain();
    write_reg(CFG_TLEN, 16'd0);
    write_reg(CFG_CCOUNT, 16'd1);
    send_req(req(FUNC_TICK, 4'h0, 32'h0, 17'h0, 4'h0, 4'h0));
    send_req(req(FUNC_LOAD, 4'h0, 32'h0, 17'h0_8000, 4'hF, 4'h3));
    send_req(req(FUNC_RESTART, 4'h0, 32'h0, 17'h0, 4'h0, 4'h0));

    // longest fade, count field above the palette size
    drain();
    write_reg(CFG_TLEN, 16'hFFFF);
    write_reg(CFG_CCOUNT, 16'hFFFF);
    send_req(req(FUNC_LOAD, 4'h0, 32'h0, PHASE_ONE, 4'hE, 4'hF));
    send_req(req(FUNC_TICK, 4'h0, 32'h0, 17'h0, 4'h0, 4'h0));
    send_req(req(FUNC_LOAD, 4'h0, 32'h0, PHASE_ONE, 4'hF, 4'h0));

    // shrink T below the frame and the count below the indices
    drain();
    write_reg(CFG_TLEN, 16'd3);
    write_reg(CFG_CCOUNT, 16'd4);
    send_req(req(FUNC_WRITE, 4'h2, 32'hFF00_FF00, 17'h0, 4'h0, 4'h0));
    repeat (5) send_req(req(FUNC_TICK, 4'h0, 32'h0, 17'h0, 4'h0, 4'h0));

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      if (p == RAND_PHASES - 1) steady = 1'b1;
      case (p)
        0: begin tl = 16'd1;     cc = 5'd16; end
        1: begin tl = 16'd0;     cc = 5'd1;  end
        2: begin tl = 16'hFFFF;  cc = 5'd31; end
        3: begin tl = 16'd2;     cc = 5'd17; end
        4: begin tl = 16'd5;     cc = 5'd0;  end
        default: begin tl = random_tlen(); cc = CC_W'($urandom_range(0, 31)); end
      endcase
      write_reg(CFG_TLEN, tl);
      write_reg(CFG_CCOUNT, {11'($urandom), cc});
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 5 && i == PHASE_ITEMS / 2) drain();
        send_req(random_req());
      end
    end

    drain();
    repeat (60) @(negedge clk);
    $display("Sent %0d requests: %0d ticks, %0d palette writes, %0d state loads, %0d restarts",
             fn_count[0] + fn_count[1] + fn_count[2] + fn_count[3],
             fn_count[FUNC_TICK], fn_count[FUNC_WRITE], fn_count[FUNC_LOAD],
             fn_count[FUNC_RESTART]);
    $display("%0d register writes, %0d colors compared", reg_writes, checked);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
